// ===== hw/rtl/sha1_pkg.sv =====
package sha1_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_DEPTH_LOG2 = 2;
  localparam int unsigned WORD_BYTES = 4;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Kind of word handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_END  = 2'd1,
    CMD_BOTH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PAD   = 3'd1,
    ST_LEN   = 3'd2,
    ST_LOAD  = 3'd3,
    ST_ROUND = 3'd4,
    ST_ADD   = 3'd5,
    ST_OUT   = 3'd6
  } eng_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

// ===== hw/rtl/sha1_in_if.sv =====
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// ===== hw/rtl/sha1_out_if.sv =====
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha1_ram.sv =====
module sha1_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sha1_front.sv =====
module sha1_front (
  input  logic              clk,
  input  logic              rst_n,
  sha1_in_if.sink           in_ch,
  output logic              cmd_valid,
  output sha1_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  localparam int unsigned AW = sha1_pkg::QUEUE_DEPTH_LOG2;

  sha1_pkg::cmd_t q_r [sha1_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_r, rd_r;
  logic [AW:0]    cnt_r;
  logic           push;
  sha1_pkg::cmd_t new_cmd;

  // Classify the word; empty words are dropped here.
  always_comb begin
    new_cmd.data = in_ch.data_byte;
    if (in_ch.byte_valid && in_ch.end_of_message) begin
      new_cmd.kind = sha1_pkg::CMD_BOTH;
    end else if (in_ch.end_of_message) begin
      new_cmd.kind = sha1_pkg::CMD_END;
    end else begin
      new_cmd.kind = sha1_pkg::CMD_BYTE;
    end
  end

  assign in_ch.ready = (cnt_r != (AW+1)'(sha1_pkg::QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_valid || in_ch.end_of_message);
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rd_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= new_cmd;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (cmd_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(cmd_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(sha1_pkg::QUEUE_DEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == (AW+1)'(sha1_pkg::QUEUE_DEPTH) && !cmd_pop |=> !push || cmd_pop)
    else $error("push while full");

endmodule

// ===== hw/rtl/sha1_engine.sv =====
module sha1_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  sha1_pkg::cmd_t cmd,
  output logic           cmd_pop,
  sha1_out_if.source     out_ch
);

  sha1_pkg::eng_state_t state_r, state_nxt;

  // Byte store, written one byte at a time; read a word per cycle.
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        bwe;
  logic [5:0]  bwaddr;
  logic [7:0]  bwdata;
  logic [3:0]  lidx_r, lidx_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        final_r, final_nxt;
  logic        padded_r, padded_nxt;
  logic        len_done_r;
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [2:0]  oidx_r, oidx_nxt;
  logic        oval_r, oval_nxt;
  logic [7:0]  rb0, rb1, rb2, rb3;

  // Four byte lanes, each a small RAM holding one byte of every word.
  logic [3:0] lane_we;
  always_comb begin
    for (int i = 0; i < 4; i++) lane_we[i] = bwe && (bwaddr[1:0] == 2'(i));
  end
  sha1_ram #(.WIDTH(8), .DEPTH(16)) u_l0 (.clk, .we(lane_we[0]), .waddr(bwaddr[5:2]),
    .wdata(bwdata), .raddr(lidx_nxt), .rdata(rb0));
  sha1_ram #(.WIDTH(8), .DEPTH(16)) u_l1 (.clk, .we(lane_we[1]), .waddr(bwaddr[5:2]),
    .wdata(bwdata), .raddr(lidx_nxt), .rdata(rb1));
  sha1_ram #(.WIDTH(8), .DEPTH(16)) u_l2 (.clk, .we(lane_we[2]), .waddr(bwaddr[5:2]),
    .wdata(bwdata), .raddr(lidx_nxt), .rdata(rb2));
  sha1_ram #(.WIDTH(8), .DEPTH(16)) u_l3 (.clk, .we(lane_we[3]), .waddr(bwaddr[5:2]),
    .wdata(bwdata), .raddr(lidx_nxt), .rdata(rb3));

  // Round function for the current round.
  logic [31:0] wt, f, k, tmp, wnew;
  always_comb begin
    wnew = sha1_pkg::rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 5'd1);
    wt = (rnd_r < 7'd16) ? w_r[0] : wnew;
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K3;
    end
    tmp = sha1_pkg::rotl(a_r, 5'd5) + f + e_r + k + wt;
  end

  // Control sequencer.
  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    lidx_nxt = lidx_r;
    rnd_nxt = rnd_r;
    final_nxt = final_r;
    padded_nxt = padded_r;
    oidx_nxt = oidx_r;
    oval_nxt = oval_r;
    cmd_pop = 1'b0;
    bwe = 1'b0;
    bwaddr = fill_r;
    bwdata = cmd.data;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == sha1_pkg::CMD_BYTE || cmd.kind == sha1_pkg::CMD_BOTH) begin
            bwe = 1'b1;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
            final_nxt = (cmd.kind == sha1_pkg::CMD_BOTH);
            if (fill_r == 6'd63) begin
              state_nxt = sha1_pkg::ST_LOAD;
              lidx_nxt = '0;
              padded_nxt = 1'b0;
            end else if (cmd.kind == sha1_pkg::CMD_BOTH) begin
              state_nxt = sha1_pkg::ST_PAD;
              padded_nxt = 1'b0;
            end
          end else begin
            final_nxt = 1'b1;
            padded_nxt = 1'b0;
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        // First the 0x80 mark, then zeros up to the length field or block end.
        bwe = 1'b1;
        bwdata = padded_r ? 8'h00 : sha1_pkg::PAD_BYTE;
        padded_nxt = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          state_nxt = sha1_pkg::ST_LOAD;
          lidx_nxt = '0;
        end else if (fill_r == 6'd55) begin
          state_nxt = sha1_pkg::ST_LEN;
        end
      end
      sha1_pkg::ST_LEN: begin
        bwe = 1'b1;
        bwdata = 8'(bits_r >> (7'd56 - {fill_r[2:0], 3'b000}));
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          state_nxt = sha1_pkg::ST_LOAD;
          lidx_nxt = '0;
        end
      end
      sha1_pkg::ST_LOAD: begin
        // Word lidx_r is on the lane outputs in this cycle.
        lidx_nxt = lidx_r + 4'd1;
        rnd_nxt = '0;
        if (lidx_r == 4'd15) begin
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) state_nxt = sha1_pkg::ST_ADD;
      end
      sha1_pkg::ST_ADD: begin
        if (final_r && !padded_r) begin
          // Message ended exactly at a block edge: pad in a new block.
          state_nxt = sha1_pkg::ST_PAD;
        end else if (final_r && padded_r && !len_done_r) begin
          state_nxt = sha1_pkg::ST_PAD;
        end else if (final_r) begin
          state_nxt = sha1_pkg::ST_OUT;
          oidx_nxt = '0;
          oval_nxt = 1'b1;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd4) begin
            oidx_nxt = '0;
            oval_nxt = 1'b0;
            state_nxt = sha1_pkg::ST_IDLE;
            bits_nxt = '0;
            final_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // Set when the length field has been written into the block in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_done_r <= 1'b0;
    end else if (state_r == sha1_pkg::ST_LEN) begin
      len_done_r <= 1'b1;
    end else if (state_r == sha1_pkg::ST_OUT || state_r == sha1_pkg::ST_IDLE) begin
      len_done_r <= 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      lidx_r <= '0;
      rnd_r <= '0;
      final_r <= 1'b0;
      padded_r <= 1'b0;
      oidx_r <= '0;
      oval_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      lidx_r <= lidx_nxt;
      rnd_r <= rnd_nxt;
      final_r <= final_nxt;
      padded_r <= padded_nxt;
      oidx_r <= oidx_nxt;
      oval_r <= oval_nxt;
    end
  end

  // Chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == sha1_pkg::ST_OUT && out_ch.ready && oidx_r == 3'd4)) begin
      h_r[0] <= sha1_pkg::H0_INIT;
      h_r[1] <= sha1_pkg::H1_INIT;
      h_r[2] <= sha1_pkg::H2_INIT;
      h_r[3] <= sha1_pkg::H3_INIT;
      h_r[4] <= sha1_pkg::H4_INIT;
    end else if (state_r == sha1_pkg::ST_ADD) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  // Schedule window and working variables.
  always_ff @(posedge clk) begin
    if (state_r == sha1_pkg::ST_LOAD) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= {rb0, rb1, rb2, rb3};
    end else if (state_r == sha1_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
    end
    if (state_r == sha1_pkg::ST_LOAD) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (state_r == sha1_pkg::ST_ROUND) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= sha1_pkg::rotl(b_r, 5'd30);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign out_ch.valid = oval_r;
  assign out_ch.digest_word = h_r[oidx_r];
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = (oidx_r == 3'd4);

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1_pkg::ST_ROUND |-> rnd_r < 7'd80) else $error("round overrun");
  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> state_r == sha1_pkg::ST_OUT) else $error("stray output");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == sha1_pkg::ST_IDLE) else $error("pop while busy");

endmodule

// ===== hw/rtl/sha1_hash_stream_unit.sv =====
// Sequence: after the engine pops an end word it writes the padding, then for each block it
// loads the words, runs the 80 rounds and adds; two blocks when the message tail reaches
// past byte 55 or fills the block exactly with the end on its last byte.
// Throughput: one word per cycle into a four-entry queue while it is not full; the engine
// takes bytes only when idle; digest words leave one per cycle while out_ch.ready is high.
// Reset: synchronous active-low rst_n clears the queue and restores the initial chaining value.
module sha1_hash_stream_unit (
  input logic        clk,
  input logic        rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  logic           cmd_valid;
  logic           cmd_pop;
  sha1_pkg::cmd_t cmd;

  sha1_front u_front (.clk, .rst_n, .in_ch, .cmd_valid, .cmd, .cmd_pop);
  sha1_engine u_engine (.clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .out_ch);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Keeps a SHA-1 predictor of the stream and the digest words that it still expects.
class sha1_scoreboard;
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic [31:0]  chain[5];
  logic [7:0]   block_bytes[64];
  int           fill;
  logic [63:0]  bit_count;
  digest_word_t digest_q[$];
  int           errors;
  int           digests_seen;

  function new();
    errors = 0;
    digests_seen = 0;
    restart();
  endfunction

  // Returns to the initial chaining value with an empty message.
  function void restart();
    chain[0] = sha1_pkg::H0_INIT;
    chain[1] = sha1_pkg::H1_INIT;
    chain[2] = sha1_pkg::H2_INIT;
    chain[3] = sha1_pkg::H3_INIT;
    chain[4] = sha1_pkg::H4_INIT;
    fill = 0;
    bit_count = '0;
  endfunction

  // Runs the 80 rounds over the current block and folds them into the chain.
  function void compress();
    logic [31:0] sched[16];
    logic [31:0] a, b, c, d, e, f, k, wt, t;
    for (int r = 0; r < 16; r++) begin
      sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = sched[r];
      end else begin
        wt = sched[(r+13)&15] ^ sched[(r+8)&15] ^ sched[(r+2)&15] ^ sched[r&15];
        wt = {wt[30:0], wt[31]};
        sched[r&15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  // Takes one accepted input word and queues the digest if it ends the message.
  function void note_word(logic [7:0] data_byte, logic byte_valid, logic end_of_message);
    digest_word_t dw;
    if (byte_valid) begin
      block_bytes[fill] = data_byte;
      fill++;
      bit_count += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!end_of_message) return;
    block_bytes[fill] = sha1_pkg::PAD_BYTE;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) block_bytes[i] = 8'h00;
      compress();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) block_bytes[i] = 8'h00;
    for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_count[63-8*i -: 8];
    compress();
    for (int i = 0; i < 5; i++) begin
      dw.digest_word = chain[i];
      dw.word_index = i[2:0];
      dw.last_word = (i == 4);
      digest_q.push_back(dw);
    end
    restart();
  endfunction

  // Compares one delivered digest word with the oldest one expected.
  function void check_word(logic [31:0] digest_word, logic [2:0] word_index, logic last_word);
    digest_word_t exp_w;
    if (digest_q.size() == 0) begin
      $error("digest word 0x%08h arrived with none expected", digest_word);
      errors++;
      return;
    end
    exp_w = digest_q.pop_front();
    if (last_word) digests_seen++;
    if (digest_word !== exp_w.digest_word) begin
      $error("digest_word: expected 0x%08h, got 0x%08h", exp_w.digest_word, digest_word);
      errors++;
    end
    if (word_index !== exp_w.word_index) begin
      $error("word_index: expected %0d, got %0d", exp_w.word_index, word_index);
      errors++;
    end
    if (last_word !== exp_w.last_word) begin
      $error("last_word: expected %0b, got %0b", exp_w.last_word, last_word);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic quiet;
  int   words_sent;
  int   stall_cycles;
  bit   hold_done;
  int   hold_left;

  sha1_scoreboard digest_sb;

  sha1_in_if  in_ch();
  sha1_out_if out_ch();

  sha1_hash_stream_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both channels at the rising edge and feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      stall_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        digest_sb.note_word(in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message);
        stall_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        digest_sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        stall_cycles = 0;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off once traffic is flowing.
  initial begin
    out_ch.ready = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!hold_done && words_sent >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = quiet || ($urandom_range(99) >= 17);
      end
    end
  end

  // Offers one word and waits until it is taken.
  task automatic send_word(input logic [7:0] data_byte, input logic byte_valid,
                           input logic end_of_message);
    while (!quiet && $urandom_range(99) < 17) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = data_byte;
    in_ch.byte_valid = byte_valid;
    in_ch.end_of_message = end_of_message;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Sends a message of random bytes with empty words mixed in, the end on the last byte or on its own word.
  task automatic send_message(input int len, input bit end_alone);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, !end_alone && (i == len - 1));
    end
    if (end_alone || len == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int pick;
    digest_sb = new();
    quiet = 1'b0;
    words_sent = 0;
    stall_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.end_of_message = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty words, the empty message, "abc", extreme bytes.
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h55, 1'b0, 1'b1);
    send_word(8'hAA, 1'b0, 1'b0);

    // Random messages, lengths weighted toward the padding boundaries.
    while (words_sent < 500) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        len = $urandom_range(20);
      end else if (pick < 8) begin
        case ($urandom_range(7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(140);
      end
      quiet = (words_sent >= 250 && words_sent < 350);
      send_message(len, 1'($urandom_range(1)));
    end
    in_ch.valid = 1'b0;
    quiet = 1'b0;

    while (digest_sb.digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (digest_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
